/* src/lle_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the light level estimator.
// Holds payload structs, register indexes and the sequencer control word.
// No dependencies.
package lle_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int CAPTURE_W      = 16;
	localparam int AVG_W          = 17;
	localparam int BOUND_W        = 17;
	localparam int LAMBDA_W       = 5;
	localparam int MAX_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 17;
	localparam int PROD_W         = BOUND_W + MAX_W;

	// brightness = floor(2^31 / (m + 1)) >> 15, i.e. floor(2^16 / (m + 1))
	localparam int SCALE_LOG   = 31;
	localparam int SCALE_SHIFT = SCALE_LOG - 16;
	localparam int BRIGHT_NUM  = 1 << (SCALE_LOG - SCALE_SHIFT);

	localparam logic [LAMBDA_W-1:0] LAMBDA_RST = LAMBDA_W'(4);
	localparam logic [BOUND_W-1:0]  LOW_RST    = '0;
	localparam logic [BOUND_W-1:0]  HIGH_RST   = BOUND_W'(65536);
	localparam logic [MAX_W-1:0]    MAX_RST    = MAX_W'(255);

	typedef struct packed {
		logic                 captured;
		logic [CAPTURE_W-1:0] capture_count;
	} meas_t;

	typedef struct packed {
		logic [MAX_W-1:0] relative_brightness;
		logic [AVG_W-1:0] average_brightness;
	} level_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAMBDA = 2'd0,
		CFG_LOW    = 2'd1,
		CFG_HIGH   = 2'd2,
		CFG_MAX    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_B,
		ST_WAIT_B,
		ST_AVG,
		ST_DIFF,
		ST_MUL,
		ST_DIV_R,
		ST_WAIT_R,
		ST_WAIT_LVL,
		ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NO_MEAS,
		COND_DIV_BUSY,
		COND_LVL_FULL
	} cond_t;

	typedef enum logic {
		DSEL_BRIGHT,
		DSEL_RELATIVE
	} dsel_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  ld_meas;
		logic  div_start;
		dsel_t div_sel;
		logic  ld_avg;
		logic  ld_diff;
		logic  ld_mul;
		logic  ld_level;
	} ctl_t;

	typedef struct packed {
		logic meas_valid;
		logic div_busy;
		logic level_full;
	} stat_t;

endpackage

/* src/lle_seq.sv */
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on lle_pkg.
module lle_seq
	import lle_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	step_t pc_q;
	step_t pc_d;
	logic  take;

	function automatic ctl_t rom(input step_t s);
		ctl_t w;
		w = '0;
		w.cond = COND_NONE;
		w.target = ST_IDLE;
		w.div_sel = DSEL_BRIGHT;
		case (s)
			ST_IDLE: begin
				w.ld_meas = 1'b1;
				w.cond = COND_NO_MEAS;
				w.target = ST_IDLE;
			end
			ST_DIV_B: begin
				w.div_start = 1'b1;
				w.div_sel = DSEL_BRIGHT;
			end
			ST_WAIT_B: begin
				w.cond = COND_DIV_BUSY;
				w.target = ST_WAIT_B;
			end
			ST_AVG:  w.ld_avg = 1'b1;
			ST_DIFF: w.ld_diff = 1'b1;
			ST_MUL:  w.ld_mul = 1'b1;
			ST_DIV_R: begin
				w.div_start = 1'b1;
				w.div_sel = DSEL_RELATIVE;
			end
			ST_WAIT_R: begin
				w.cond = COND_DIV_BUSY;
				w.target = ST_WAIT_R;
			end
			ST_WAIT_LVL: begin
				w.cond = COND_LVL_FULL;
				w.target = ST_WAIT_LVL;
			end
			ST_EMIT: begin
				w.ld_level = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		ctl = rom(pc_q);
		case (ctl.cond)
			COND_NONE:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_MEAS:  take = !stat.meas_valid;
			COND_DIV_BUSY: take = stat.div_busy;
			COND_LVL_FULL: take = stat.level_full;
			default:       take = 1'b1;
		endcase
		pc_d = take ? ctl.target : step_t'(pc_q + 4'd1);
	end

endmodule

/* src/lle_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on lle_pkg for default widths.
module lle_div
	import lle_pkg::*;
#(
	parameter int DEND_W = PROD_W,
	parameter int DSOR_W = AVG_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEND_W-1:0] dividend,
	input  logic [DSOR_W-1:0] divisor,
	output logic              busy,
	output logic [DEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DEND_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DSOR_W-1:0] rem_q;
	logic [DSOR_W-1:0] dsor_q;
	logic [DEND_W-1:0] quo_q;
	logic [DSOR_W:0]   trial;
	logic [DSOR_W:0]   trial_sub;
	logic              fits;

	// quo_q shifts dividend bits out at the top and quotient bits in at the bottom
	assign trial     = {rem_q, quo_q[DEND_W-1]};
	assign trial_sub = trial - {1'b0, dsor_q};
	assign fits      = trial >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsor_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DSOR_W-1:0] : trial[DSOR_W-1:0];
			quo_q <= {quo_q[DEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* src/lle_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, average, scaling and the result register.
// Depends on lle_pkg; driven by the control word from lle_seq.
module lle_dp
	import lle_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int DSOR_W     = AVG_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	output stat_t                 stat,
	input  logic                  meas_valid,
	output logic                  meas_ready,
	input  meas_t                 meas_data,
	output logic                  level_valid,
	input  logic                  level_ready,
	output level_t                level_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  div_start,
	output logic [PROD_W-1:0]     div_dividend,
	output logic [DSOR_W-1:0]     div_divisor,
	input  logic                  div_busy,
	input  logic [PROD_W-1:0]     div_quotient
);

	localparam int EXT_W = (COUNT_BITS > CAPTURE_W) ? COUNT_BITS : CAPTURE_W;

	logic [LAMBDA_W-1:0] lambda_q;
	logic [BOUND_W-1:0]  low_q;
	logic [BOUND_W-1:0]  high_q;
	logic [MAX_W-1:0]    max_q;
	logic [AVG_W-1:0]    avg_q;
	logic                level_valid_q;

	logic [DSOR_W-1:0]   m1_q;
	logic [BOUND_W-1:0]  diff_q;
	logic [BOUND_W-1:0]  span_q;
	logic                zero_q;
	logic [PROD_W-1:0]   prod_q;
	level_t              level_q;

	logic [EXT_W-1:0]      count_ext;
	logic [COUNT_BITS-1:0] m_sel;
	logic [AVG_W-1:0]      bright;
	logic [AVG_W-1:0]      avg_dec;
	logic [AVG_W:0]        avg_sum;
	logic                  over;
	logic [MAX_W-1:0]      rel;
	logic                  meas_fire;

	assign meas_ready = ctl.ld_meas;
	assign meas_fire  = meas_valid && ctl.ld_meas;

	// a timeout reads as the all-ones count
	assign count_ext = EXT_W'(meas_data.capture_count);
	assign m_sel     = meas_data.captured ? count_ext[COUNT_BITS-1:0] : '1;

	assign bright  = div_quotient[AVG_W-1:0];
	assign avg_dec = avg_q - (avg_q >> lambda_q);
	assign avg_sum = {1'b0, avg_dec} + {1'b0, bright >> lambda_q};

	assign over = div_quotient > PROD_W'(max_q);
	assign rel  = zero_q ? '0 : (over ? max_q : div_quotient[MAX_W-1:0]);

	assign div_start    = ctl.div_start;
	assign div_dividend = (ctl.div_sel == DSEL_BRIGHT) ? PROD_W'(BRIGHT_NUM) : prod_q;
	assign div_divisor  = (ctl.div_sel == DSEL_BRIGHT) ? m1_q : DSOR_W'(span_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= LAMBDA_RST;
			low_q <= LOW_RST;
			high_q <= HIGH_RST;
			max_q <= MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LAMBDA: lambda_q <= cfg_data[LAMBDA_W-1:0];
				CFG_LOW:    low_q <= cfg_data[BOUND_W-1:0];
				CFG_HIGH:   high_q <= cfg_data[BOUND_W-1:0];
				CFG_MAX:    max_q <= cfg_data[MAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			level_valid_q <= 1'b0;
		end else begin
			if (ctl.ld_avg) begin
				avg_q <= avg_sum[AVG_W-1:0];
			end
			if (ctl.ld_level) begin
				level_valid_q <= 1'b1;
			end else if (level_ready) begin
				level_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meas_fire) begin
			m1_q <= DSOR_W'(m_sel) + DSOR_W'(1);
		end
		if (ctl.ld_diff) begin
			diff_q <= avg_q - low_q;
			span_q <= high_q - low_q;
			zero_q <= (high_q <= low_q) || (avg_q <= low_q);
		end
		if (ctl.ld_mul) begin
			prod_q <= PROD_W'(diff_q) * PROD_W'(max_q);
		end
		if (ctl.ld_level) begin
			level_q.relative_brightness <= rel;
			level_q.average_brightness <= avg_q;
		end
	end

	assign level_valid = level_valid_q;
	assign level_data  = level_q;

	assign stat.meas_valid = meas_valid;
	assign stat.div_busy   = div_busy;
	assign stat.level_full = level_valid_q;

endmodule

/* src/rc_light_level_estimator.sv */
`timescale 1ns / 1ps
// RC discharge-time light level estimator, top level.
// Depends on lle_pkg, lle_seq, lle_dp and lle_div.
//
// Channels: meas (valid/ready) takes one discharge-time word per item, either a
// captured count or a timeout. level (valid/ready) returns one word per item:
// the scaled, clamped relative brightness and the running average. cfg
// (valid/ready, always ready) writes lambda_bits, low_bound, high_bound and
// max_level by index; write it only while the block is idle.
// Both divisions (reciprocal brightness, then the linear mapping) run on one
// restoring divider at one quotient bit per cycle, and the microcode
// sequencer handles one item at a time, so a new item is taken only once the
// sequencer has finished the previous one. meas_ready is high only while the
// sequencer sits at its idle step.
// The result register frees the input side: a new word is accepted while the
// previous result still waits; if the receiver stalls long enough, the
// sequencer holds before loading the next result.
// Reset clears the average to zero and loads the configuration defaults
// (shift 4, range 0..65536, full scale 255). No clearing pass is needed.
module rc_light_level_estimator
	import lle_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  meas_valid,
	output logic                  meas_ready,
	input  meas_t                 meas_data,
	output logic                  level_valid,
	input  logic                  level_ready,
	output level_t                level_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DSOR_W = (COUNT_BITS + 1 > AVG_W) ? COUNT_BITS + 1 : AVG_W;

	ctl_t              ctl;
	stat_t             stat;
	logic              div_start;
	logic              div_busy;
	logic [PROD_W-1:0] div_dividend;
	logic [DSOR_W-1:0] div_divisor;
	logic [PROD_W-1:0] div_quotient;

	assign cfg_ready = 1'b1;

	lle_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	lle_dp #(
		.COUNT_BITS (COUNT_BITS),
		.DSOR_W     (DSOR_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.meas_valid   (meas_valid),
		.meas_ready   (meas_ready),
		.meas_data    (meas_data),
		.level_valid  (level_valid),
		.level_ready  (level_ready),
		.level_data   (level_data),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_busy     (div_busy),
		.div_quotient (div_quotient)
	);

	lle_div #(
		.DEND_W (PROD_W),
		.DSOR_W (DSOR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quotient)
	);

endmodule

/* src/lle_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the light level estimator, bound to the top level.
// Depends on lle_pkg.
module lle_chk
	import lle_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   meas_valid,
	input logic   meas_ready,
	input logic   level_valid,
	input logic   level_ready,
	input level_t level_data
);

	// a stalled result word holds
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid && !level_ready |=> level_valid && $stable(level_data))
		else $error("level word changed or dropped while stalled");

	// one item at a time: no back-to-back accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready)
		else $error("measurement accepted while busy");

	// a result never appears right after its word is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !$rose(level_valid) ##1 !$rose(level_valid))
		else $error("result appeared too early");

	// the average never exceeds full brightness
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid |-> level_data.average_brightness <= AVG_W'(BRIGHT_NUM))
		else $error("average out of range");

endmodule

bind rc_light_level_estimator lle_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.meas_valid  (meas_valid),
	.meas_ready  (meas_ready),
	.level_valid (level_valid),
	.level_ready (level_ready),
	.level_data  (level_data)
);
